@@ sv/tpi_pkg.sv @@
// Shared types and constants for the three-plane intersection unit.
// No dependencies; imported by the top level, the divider and the checker.
`default_nettype none
package tpi_pkg;

  localparam int unsigned DW      = 32;   // field width of normals, offsets, points
  localparam int unsigned CW      = 65;   // cross product width, Q4.60
  localparam int unsigned SW      = 99;   // determinant and weighted sum width
  localparam int unsigned THR_W   = 63;   // det_threshold width
  localparam int unsigned QW      = 33;   // rounded quotient width
  localparam int unsigned QBITS   = 32;   // quotient bits developed by the divider
  localparam int unsigned RW      = 131;  // divider partial remainder width
  localparam int unsigned DIV_LAT = QBITS + 2;

  localparam logic [THR_W-1:0] THR_RESET = 63'd115292150;

  localparam logic [1:0] ST_POINT = 2'd0;
  localparam logic [1:0] ST_PARAL = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic [0:0] REG_DET_THR = 1'b0;

  // one plane, last field (nx) in the lowest bits
  typedef struct packed {
    logic signed [DW-1:0] off;
    logic signed [DW-1:0] nz;
    logic signed [DW-1:0] ny;
    logic signed [DW-1:0] nx;
  } plane_t;

  typedef plane_t [2:0] planes_t;

  typedef struct packed {
    logic signed [DW-1:0] z;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] x;
  } point_t;

endpackage
`default_nettype wire

@@ sv/tpi_div.sv @@
// Pipelined restoring divider: round(num * 2^30 / den), one quotient bit per stage.
// Depends on tpi_pkg.
`default_nettype none
module tpi_div
  import tpi_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [SW-1:0] num_i,
  input  wire logic [SW-1:0] den_i,
  output logic      [QW-1:0] q_o,
  output logic               ovf_o
);

  logic [RW-1:0]    r_q   [QBITS+1];
  logic [QBITS-1:0] qb_q  [QBITS+1];
  logic [SW-1:0]    den_q [QBITS+1];
  logic             ovf_q [QBITS+1];
  logic [RW-1:0]    r_d   [QBITS+1];
  logic [QBITS-1:0] qb_d  [QBITS+1];
  logic [QW-1:0]    q_q;
  logic             ovf_out_q;
  logic [RW-1:0]    sub;
  logic [RW-1:0]    trial;

  always_comb begin
    r_d[0]  = {2'b00, num_i, 30'd0};
    qb_d[0] = '0;
    for (int k = 1; k <= QBITS; k++) begin
      sub   = {{(RW-SW){1'b0}}, den_q[k-1]} << (QBITS - k);
      trial = r_q[k-1] - sub;
      r_d[k]  = r_q[k-1];
      qb_d[k] = qb_q[k-1];
      if (r_q[k-1] >= sub) begin
        r_d[k]            = trial;
        qb_d[k][QBITS-k]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= r_d[0];
      qb_q[0]  <= qb_d[0];
      den_q[0] <= den_i;
      // quotient would need more than 32 bits: saturate downstream
      ovf_q[0] <= {2'b00, num_i} >= {den_i, 2'b00};
      for (int k = 1; k <= QBITS; k++) begin
        r_q[k]   <= r_d[k];
        qb_q[k]  <= qb_d[k];
        den_q[k] <= den_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
      // round half away from zero on the magnitude
      q_q       <= {1'b0, qb_q[QBITS]} +
                   QW'({r_q[QBITS][RW-2:0], 1'b0} >= {{(RW-SW){1'b0}}, den_q[QBITS]});
      ovf_out_q <= ovf_q[QBITS];
    end
  end

  assign q_o   = q_q;
  assign ovf_o = ovf_out_q;

endmodule
`default_nettype wire

@@ sv/three_plane_intersect_unit.sv @@
// Top level of the three-plane intersection unit (Cramer's rule, fixed point).
// Depends on tpi_pkg and tpi_div.
//
//   channel   direction  payload (lowest bits first)
//   s_axis    in         tdata: n0_x n0_y n0_z off0 n1_x n1_y n1_z off1 n2_x ... off2
//   m_axis    out        tdata: pt_x pt_y pt_z; tuser: status
//   apb       in         det_threshold at byte address 0 (64-bit data)
//
// One transfer per cycle in each direction while the output is not stalled. The
// path runs through six arithmetic stages (products, cross products, partial
// products, terms, sums, magnitudes), 34 divider stages (operand load, one stage
// per quotient bit for 32 bits, rounding) and the output register. The divider
// bit stages set the depth. Reset clears the valid bits and loads det_threshold;
// a stalled output holds the whole pipeline in place.
`default_nettype none
module three_plane_intersect_unit
  import tpi_pkg::*;
#(
  parameter logic [THR_W-1:0] DetThrReset = THR_RESET
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [383:0] s_axis_tdata_i,   // n0_x n0_y n0_z off0 n1_x .. off1 n2_x .. off2
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [95:0]       m_axis_tdata_o,   // pt_x pt_y pt_z
  output logic [1:0]        m_axis_tuser_o,   // status
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  typedef struct packed {
    logic       par;
    logic [2:0] neg;
  } side_t;

  // ---------------- configuration
  logic [THR_W-1:0] thr_q;
  logic [0:0]       reg_idx;

  assign reg_idx = paddr[3:3];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= DetThrReset;
    end else if (psel && penable && pwrite && reg_idx == REG_DET_THR) begin
      thr_q <= pwdata[THR_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DET_THR: prdata = {1'b0, thr_q};
      default:     prdata = '0;
    endcase
  end

  // ---------------- flow control: advance all stages together
  logic en;
  logic out_v_q;

  assign en              = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  planes_t pin;
  assign pin = planes_t'(s_axis_tdata_i);

  logic signed [DW-1:0] nv [3][3];
  always_comb begin
    for (int p = 0; p < 3; p++) begin
      nv[p][0] = pin[p].nx;
      nv[p][1] = pin[p].ny;
      nv[p][2] = pin[p].nz;
    end
  end

  // ---------------- stage a: the 18 products of the cross products
  logic                 va_q;
  logic signed [63:0]   pa_d [3][3];
  logic signed [63:0]   pb_d [3][3];
  logic signed [63:0]   pa_q [3][3];
  logic signed [63:0]   pb_q [3][3];
  logic signed [DW-1:0] n0a_q [3];
  logic signed [DW-1:0] offa_q [3];

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      pa_d[p][0] = nv[(p+1)%3][1] * nv[(p+2)%3][2];
      pb_d[p][0] = nv[(p+1)%3][2] * nv[(p+2)%3][1];
      pa_d[p][1] = nv[(p+1)%3][2] * nv[(p+2)%3][0];
      pb_d[p][1] = nv[(p+1)%3][0] * nv[(p+2)%3][2];
      pa_d[p][2] = nv[(p+1)%3][0] * nv[(p+2)%3][1];
      pb_d[p][2] = nv[(p+1)%3][1] * nv[(p+2)%3][0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int p = 0; p < 3; p++) begin
        for (int k = 0; k < 3; k++) begin
          pa_q[p][k] <= pa_d[p][k];
          pb_q[p][k] <= pb_d[p][k];
        end
        n0a_q[p]  <= nv[0][p];
        offa_q[p] <= pin[p].off;
      end
    end
  end

  // ---------------- stage b: cross products, Q4.60
  logic                 vb_q;
  logic signed [CW-1:0] c_q [3][3];
  logic signed [DW-1:0] n0b_q [3];
  logic signed [DW-1:0] offb_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int p = 0; p < 3; p++) begin
        for (int k = 0; k < 3; k++) begin
          c_q[p][k] <= {pa_q[p][k][63], pa_q[p][k]} - {pb_q[p][k][63], pb_q[p][k]};
        end
        n0b_q[p]  <= n0a_q[p];
        offb_q[p] <= offa_q[p];
      end
    end
  end

  // ---------------- stage c: split 65x32 products into two partial products
  // dt*: determinant terms C0[k]*n0[k]; st*[k][p]: sum terms Cp[k]*off[p]
  logic                 vc_q;
  logic signed [CW-1:0] dth_d [3];
  logic signed [CW-1:0] dtl_d [3];
  logic signed [CW-1:0] sth_d [3][3];
  logic signed [CW-1:0] stl_d [3][3];
  logic signed [CW-1:0] dth_q [3];
  logic signed [CW-1:0] dtl_q [3];
  logic signed [CW-1:0] sth_q [3][3];
  logic signed [CW-1:0] stl_q [3][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dth_d[k] = $signed(c_q[0][k][64:32]) * n0b_q[k];
      dtl_d[k] = $signed({1'b0, c_q[0][k][31:0]}) * n0b_q[k];
      for (int p = 0; p < 3; p++) begin
        sth_d[k][p] = $signed(c_q[p][k][64:32]) * offb_q[p];
        stl_d[k][p] = $signed({1'b0, c_q[p][k][31:0]}) * offb_q[p];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dth_q[k] <= dth_d[k];
        dtl_q[k] <= dtl_d[k];
        for (int p = 0; p < 3; p++) begin
          sth_q[k][p] <= sth_d[k][p];
          stl_q[k][p] <= stl_d[k][p];
        end
      end
    end
  end

  // ---------------- stage d: recombine partial products
  logic                 vd_q;
  logic signed [SW-1:0] dt_q [3];
  logic signed [SW-1:0] st_q [3][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dt_q[k] <= {{2{dth_q[k][CW-1]}}, dth_q[k], 32'd0} +
                   {{(SW-CW){dtl_q[k][CW-1]}}, dtl_q[k]};
        for (int p = 0; p < 3; p++) begin
          st_q[k][p] <= {{2{sth_q[k][p][CW-1]}}, sth_q[k][p], 32'd0} +
                        {{(SW-CW){stl_q[k][p][CW-1]}}, stl_q[k][p]};
        end
      end
    end
  end

  // ---------------- stage e: determinant and weighted sums, exact
  logic                 ve_q;
  logic signed [SW-1:0] det_q;
  logic signed [SW-1:0] sum_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      det_q <= dt_q[0] + dt_q[1] + dt_q[2];
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= st_q[k][0] + st_q[k][1] + st_q[k][2];
      end
    end
  end

  // ---------------- stage f: magnitudes, signs, near-parallel test
  logic          vf_q;
  logic [SW-1:0] dmag_d;
  logic [SW-1:0] dmag_q;
  logic [SW-1:0] smag_q [3];
  logic [2:0]    neg_q;
  logic          par_q;

  assign dmag_d = det_q[SW-1] ? SW'(-det_q) : SW'(det_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      dmag_q <= dmag_d;
      par_q  <= (dmag_d == '0) || (dmag_d[SW-1:30] < {6'd0, thr_q});
      for (int k = 0; k < 3; k++) begin
        smag_q[k] <= sum_q[k][SW-1] ? SW'(-sum_q[k]) : SW'(sum_q[k]);
        neg_q[k]  <= sum_q[k][SW-1] ^ det_q[SW-1];
      end
    end
  end

  // ---------------- divider lanes, side data delayed alongside
  logic [QW-1:0] q [3];
  logic [2:0]    ovf;

  for (genvar g = 0; g < 3; g++) begin : g_div
    tpi_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (smag_q[g]),
      .den_i (dmag_q),
      .q_o   (q[g]),
      .ovf_o (ovf[g])
    );
  end

  side_t sd_q     [DIV_LAT];
  logic  sd_vld_q [DIV_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= '{par: par_q, neg: neg_q};
      for (int i = 1; i < DIV_LAT; i++) begin
        sd_q[i] <= sd_q[i-1];
      end
    end
  end

  // valid bits: reset clears them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) sd_vld_q[i] <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      va_q <= s_axis_tvalid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
      vf_q <= ve_q;
      sd_vld_q[0] <= vf_q;
      for (int i = 1; i < DIV_LAT; i++) sd_vld_q[i] <= sd_vld_q[i-1];
      out_v_q <= sd_vld_q[DIV_LAT-1];
    end
  end

  // ---------------- output stage: sign, saturation, status
  point_t        pt_d;
  point_t        pt_q;
  logic [1:0]    st_d;
  logic [1:0]    stat_q;
  logic [2:0]    sat;
  logic [QW-1:0] lim;
  logic [DW-1:0] val [3];
  side_t         sl;

  assign sl = sd_q[DIV_LAT-1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lim    = sl.neg[k] ? QW'(33'h080000000) : QW'(33'h07FFFFFFF);
      sat[k] = ovf[k] || (q[k] > lim);
      if (sat[k]) begin
        val[k] = sl.neg[k] ? 32'h80000000 : 32'h7FFFFFFF;
      end else begin
        val[k] = sl.neg[k] ? DW'(-q[k]) : q[k][DW-1:0];
      end
    end
    if (sl.par) begin
      pt_d = '0;
      st_d = ST_PARAL;
    end else begin
      pt_d.x = val[0];
      pt_d.y = val[1];
      pt_d.z = val[2];
      st_d   = (sat != 3'b000) ? ST_SAT : ST_POINT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pt_q   <= pt_d;
      stat_q <= st_d;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = pt_q;
  assign m_axis_tuser_o  = stat_q;

endmodule
`default_nettype wire

@@ sv/tpi_check.sv @@
// Port-level checker for three_plane_intersect_unit, bound to the top level.
// Depends on tpi_pkg.
`default_nettype none
module tpi_check
  import tpi_pkg::*;
(
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid_i,
  input wire logic         s_axis_tready_o,
  input wire logic [383:0] s_axis_tdata_i,
  input wire logic         m_axis_tvalid_o,
  input wire logic         m_axis_tready_i,
  input wire logic [95:0]  m_axis_tdata_o,
  input wire logic [1:0]   m_axis_tuser_o,
  input wire logic         psel,
  input wire logic         penable,
  input wire logic         pwrite,
  input wire logic [3:0]   paddr,
  input wire logic [63:0]  pwdata,
  input wire logic [63:0]  prdata,
  input wire logic         pready
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // input side stalls only behind a stalled output
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output backpressure");

  // near parallel carries a zero point
  a_paral: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == ST_PARAL |-> m_axis_tdata_o == '0)
    else $error("near-parallel result with nonzero point");

  // saturated status means some coordinate sits on a bound
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == ST_SAT |->
      m_axis_tdata_o[31:0] == 32'h7FFFFFFF || m_axis_tdata_o[31:0] == 32'h80000000 ||
      m_axis_tdata_o[63:32] == 32'h7FFFFFFF || m_axis_tdata_o[63:32] == 32'h80000000 ||
      m_axis_tdata_o[95:64] == 32'h7FFFFFFF || m_axis_tdata_o[95:64] == 32'h80000000)
    else $error("saturation flagged with no coordinate at a bound");

endmodule

bind three_plane_intersect_unit tpi_check u_tpi_check (.*);
`default_nettype wire
